[design/cst_pkg.sv]
// Shared types, constants and lookup functions for the C subset token scanner.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  localparam int MAX_IDENT_LEN = 255;
  localparam int WLEN_W        = $clog2(MAX_IDENT_LEN + 1);
  localparam int KIND_W        = 5;
  localparam int NUM_W         = 31;
  localparam int LEN_W         = 8;
  localparam int PREFIX_LEN    = 6;
  localparam int KW_COUNT      = 7;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    TK_EOF, TK_NUM, TK_IDENT,
    TK_INT, TK_IF, TK_ELSE, TK_WHILE, TK_FOR, TK_PRINT, TK_RETURN,
    TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_TILDE, TK_PERCENT,
    TK_ASSIGN, TK_EQ, TK_NE, TK_NOT, TK_LT, TK_LE, TK_GT, TK_GE,
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_SEMI, TK_AND, TK_OR,
    TK_UNKNOWN
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e        kind;
    logic [NUM_W-1:0] number_value;
    logic [LEN_W-1:0] ident_length;
    logic             overflow;
    logic             last_of_run;
  } token_t;

  // Up to two tokens per source byte; t1 is valid only together with t0.
  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } tok_pair_t;

  // Keyword text, first character in the low byte, zero padded.
  localparam logic [8*PREFIX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    {24'h0, "tni"},
    {32'h0, "fi"},
    {16'h0, "esle"},
    {8'h0,  "elihw"},
    {24'h0, "rof"},
    {8'h0,  "tnirp"},
    "nruter"
  };

  localparam int KW_LEN [KW_COUNT] = '{3, 2, 4, 5, 3, 5, 6};

  localparam tok_kind_e KW_KIND [KW_COUNT] = '{
    TK_INT, TK_IF, TK_ELSE, TK_WHILE, TK_FOR, TK_PRINT, TK_RETURN
  };

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha_u(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  // Single-character tokens; anything unlisted is unknown.
  function automatic tok_kind_e punct_kind(logic [7:0] b);
    tok_kind_e k;
    unique case (b)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      "~":     k = TK_TILDE;
      "%":     k = TK_PERCENT;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      ";":     k = TK_SEMI;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  // Bytes past the word length are zero, so a full-width compare suffices.
  function automatic tok_kind_e word_kind(logic [8*PREFIX_LEN-1:0] prefix,
                                          logic [WLEN_W-1:0]       wlen);
    tok_kind_e k;
    k = TK_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if ((wlen == WLEN_W'(KW_LEN[i])) && (prefix == KW_TEXT[i])) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[design/cst_if.sv]
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface cst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source(output valid, output source_byte, output end_of_input, input ready);
  modport sink(input valid, input source_byte, input end_of_input, output ready);
endinterface

interface cst_tok_if
  import cst_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [NUM_W-1:0]  number_value;
  logic [LEN_W-1:0]  ident_length;
  logic              overflow;
  logic              last_of_run;

  modport source(output valid, output token_kind, output number_value,
                 output ident_length, output overflow, output last_of_run,
                 input ready);
  modport sink(input valid, input token_kind, input number_value,
               input ident_length, input overflow, input last_of_run,
               output ready);
endinterface

`default_nettype wire

[design/cst_scan.sv]
// Scanner state and per-byte token decode.
`timescale 1ns / 1ps
`default_nettype none

module cst_scan
  import cst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  logic [7:0] byte_i,
  input  logic      eoi_i,
  output tok_pair_t pair_o
);

  typedef enum logic [3:0] {
    SM_IDLE, SM_NUM, SM_WORD, SM_EQ, SM_BANG, SM_LT, SM_GT, SM_AMP, SM_BAR
  } scan_mode_e;

  scan_mode_e                mode_q, mode_d;
  logic [NUM_W-1:0]          acc_q, acc_d;
  logic [WLEN_W-1:0]         wlen_q, wlen_d;
  logic [PREFIX_LEN-1:0][7:0] prefix_q, prefix_d;
  logic                      sat_q, sat_d;

  logic       flush_has, flush_v, b_v, restart;
  token_t     flush_tok, b_tok;
  tok_kind_e  b_kind;
  logic [NUM_W+3:0] acc_next;
  logic       digit, alpha;

  assign digit    = is_digit(byte_i);
  assign alpha    = is_alpha_u(byte_i);
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                    (NUM_W+4)'(byte_i - "0");

  // Token that ends the pending state.
  always_comb begin
    flush_tok           = '0;
    flush_tok.kind      = TK_UNKNOWN;
    flush_has           = 1'b1;
    unique case (mode_q)
      SM_NUM: begin
        flush_tok.kind         = TK_NUM;
        flush_tok.number_value = acc_q;
        flush_tok.overflow     = sat_q;
      end
      SM_WORD: begin
        flush_tok.kind = word_kind(prefix_q, wlen_q);
        if (flush_tok.kind == TK_IDENT) begin
          flush_tok.ident_length = LEN_W'(wlen_q);
          flush_tok.overflow     = sat_q;
        end
      end
      SM_EQ:   flush_tok.kind = TK_ASSIGN;
      SM_BANG: flush_tok.kind = TK_NOT;
      SM_LT:   flush_tok.kind = TK_LT;
      SM_GT:   flush_tok.kind = TK_GT;
      SM_AMP, SM_BAR: flush_tok.kind = TK_UNKNOWN;
      default: flush_has = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    wlen_d   = wlen_q;
    prefix_d = prefix_q;
    sat_d    = sat_q;
    flush_v  = 1'b0;
    b_v      = 1'b0;
    b_kind   = TK_UNKNOWN;
    restart  = 1'b0;

    if (eoi_i) begin
      flush_v = flush_has;
      b_v     = 1'b1;
      b_kind  = TK_EOF;
      mode_d  = SM_IDLE;
    end else begin
      unique case (mode_q)
        SM_NUM: begin
          if (digit) begin
            if (acc_next > (NUM_W+4)'(NUM_MAX)) begin
              acc_d = NUM_MAX;
              sat_d = 1'b1;
            end else begin
              acc_d = acc_next[NUM_W-1:0];
            end
          end else begin
            restart = 1'b1;
          end
        end
        SM_WORD: begin
          if (alpha || digit) begin
            if (wlen_q < WLEN_W'(MAX_IDENT_LEN)) begin
              if (wlen_q < WLEN_W'(PREFIX_LEN)) prefix_d[wlen_q[2:0]] = byte_i;
              wlen_d = wlen_q + WLEN_W'(1);
            end else begin
              sat_d = 1'b1;
            end
          end else begin
            restart = 1'b1;
          end
        end
        SM_EQ, SM_BANG, SM_LT, SM_GT: begin
          if (byte_i == "=") begin
            b_v    = 1'b1;
            mode_d = SM_IDLE;
            priority case (mode_q)
              SM_EQ:   b_kind = TK_EQ;
              SM_BANG: b_kind = TK_NE;
              SM_LT:   b_kind = TK_LE;
              default: b_kind = TK_GE;
            endcase
          end else begin
            restart = 1'b1;
          end
        end
        SM_AMP: begin
          if (byte_i == "&") begin
            b_v    = 1'b1;
            b_kind = TK_AND;
            mode_d = SM_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        SM_BAR: begin
          if (byte_i == "|") begin
            b_v    = 1'b1;
            b_kind = TK_OR;
            mode_d = SM_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      // Close the pending token, then scan this byte from idle.
      if (restart) begin
        flush_v = flush_has;
        mode_d  = SM_IDLE;
        if (is_space(byte_i)) begin
          mode_d = SM_IDLE;
        end else if (digit) begin
          mode_d = SM_NUM;
          acc_d  = NUM_W'(byte_i - "0");
          sat_d  = 1'b0;
        end else if (alpha) begin
          mode_d      = SM_WORD;
          wlen_d      = WLEN_W'(1);
          prefix_d    = '0;
          prefix_d[0] = byte_i;
          sat_d       = 1'b0;
        end else begin
          priority case (byte_i)
            "=": mode_d = SM_EQ;
            "!": mode_d = SM_BANG;
            "<": mode_d = SM_LT;
            ">": mode_d = SM_GT;
            "&": mode_d = SM_AMP;
            "|": mode_d = SM_BAR;
            default: begin
              b_v    = 1'b1;
              b_kind = punct_kind(byte_i);
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    b_tok      = '0;
    b_tok.kind = b_kind;
    b_tok.last_of_run = 1'b1;
    pair_o.v0 = take_i && (flush_v || b_v);
    pair_o.v1 = take_i && flush_v && b_v;
    pair_o.t1 = b_tok;
    if (flush_v) begin
      pair_o.t0             = flush_tok;
      pair_o.t0.last_of_run = !b_v;
    end else begin
      pair_o.t0 = b_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= SM_IDLE;
      acc_q    <= '0;
      wlen_q   <= '0;
      prefix_q <= '0;
      sat_q    <= 1'b0;
    end else if (take_i) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      wlen_q   <= wlen_d;
      prefix_q <= prefix_d;
      sat_q    <= sat_d;
    end
  end

endmodule

`default_nettype wire

[design/cst_queue.sv]
// Four-entry token queue taking up to two tokens per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cst_queue
  import cst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_pair_t push_i,
  input  logic      pop_i,
  output token_t    head_o,
  output logic      nonempty_o,
  output logic      space_o
);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = PTR_W + 1;

  token_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         n_push;

  assign wr_nxt     = wr_ptr_q + PTR_W'(1);
  assign n_push     = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign wr_ptr_d   = wr_ptr_q + PTR_W'(n_push);
  assign rd_ptr_d   = rd_ptr_q + PTR_W'(pop_i);
  assign cnt_d      = cnt_q + CNT_W'(n_push) - CNT_W'(pop_i);
  assign head_o     = mem_q[rd_ptr_q];
  assign nonempty_o = (cnt_q != '0);
  // Room for the worst case of two tokens from the next byte.
  assign space_o    = (cnt_q <= CNT_W'(QDEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_ptr_q] <= push_i.t0;
    if (push_i.v1) mem_q[wr_nxt]   <= push_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/c_subset_token_scanner_top.sv]
// Top level of the C subset token scanner.
//
// in_i carries one source byte per transaction, or an end-of-input marker
// (end_of_input high, source_byte ignored). out_o carries tokens: kind,
// number value, identifier length, overflow flag, and last_of_run marking
// the final token caused by one input transaction.
// Each accepted byte is decoded in the cycle it is accepted and its zero,
// one or two tokens are written to a four-entry token queue; the first
// token reaches out_o from the queue head once any tokens ahead are taken.
// in_i takes one byte per cycle while the queue has room for two tokens.
// Output is one token per cycle while out_o.ready is high, so sustained
// rate is one byte per cycle except where a byte closes a pending token
// and emits a second one; both tokens share the single output port.
// When out_o stalls, the queue fills and in_i.ready drops until two
// entries are free; nothing is lost or repeated.
// Reset clears the scanner to idle and empties the queue; in_i.ready is
// high as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_token_scanner_top
  import cst_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  cst_byte_if.sink        in_i,
  cst_tok_if.source       out_o
);

  tok_pair_t pair;
  token_t    head;
  logic      take, space, nonempty, pop;

  assign in_i.ready = space;
  assign take       = in_i.valid && space;
  assign pop        = nonempty && out_o.ready;

  cst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_i.source_byte),
    .eoi_i  (in_i.end_of_input),
    .pair_o (pair)
  );

  cst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (pair),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .space_o    (space)
  );

  assign out_o.valid        = nonempty;
  assign out_o.token_kind   = head.kind;
  assign out_o.number_value = head.number_value;
  assign out_o.ident_length = head.ident_length;
  assign out_o.overflow     = head.overflow;
  assign out_o.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire
